// ----- rtl/res_pkg.sv -----
// Package: sizes and record type for the record exchange sort.
`timescale 1ns / 1ps
package res_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int ADDR_W      = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
	localparam int KEY_W       = 16;
	localparam int TAG_W       = 16;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

endpackage

// ----- rtl/res_in_if.sv -----
// Interface: input record channel.
`timescale 1ns / 1ps
interface res_in_if
	import res_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] sort_key;
	logic [TAG_W-1:0] record_tag;
	logic             last_record;

	modport source (output valid, sort_key, record_tag, last_record, input ready);
	modport sink   (input valid, sort_key, record_tag, last_record, output ready);
endinterface

// ----- rtl/res_out_if.sv -----
// Interface: sorted result channel.
`timescale 1ns / 1ps
interface res_out_if
	import res_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] out_key;
	logic [TAG_W-1:0] out_tag;
	logic             final_out;
	logic             overflowed;

	modport source (output valid, out_key, out_tag, final_out, overflowed, input ready);
	modport sink   (input valid, out_key, out_tag, final_out, overflowed, output ready);
endinterface

// ----- rtl/record_exchange_sort.sv -----
// Record exchange sort: loads a set of key/tag records, sorts them and emits them in key order.
// Records arrive one per cycle until one marked last; up to MAX_RECORDS are held in a single
// RAM and later records of the set are dropped, which sets overflowed on every result of
// that set. The set is then sorted in place by an exchange sort: for each position i the
// entries i+1..n-1 are read in turn from the RAM and swapped with a held copy of entry i
// whenever that key is strictly greater, so ties keep the order that sequence leaves. Sorting
// time is bounded by the one RAM read port; results then leave one at a time, each read from
// the RAM only after the one before it is placed in the output register, the last marked by
// final_out. No input is taken between the last record of a set and the issue of its final
// result; a waiting result does not block loading of the next set.
`timescale 1ns / 1ps
module record_exchange_sort
	import res_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	res_in_if.sink    rec_in,
	res_out_if.source res_out
);
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RDI,
		ST_HEAD,
		ST_SCAN,
		ST_WBI,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [ADDR_W-1:0] i_q;
	logic [CNT_W-1:0]  j_q;
	logic [ADDR_W-1:0] j_s1;
	logic [CNT_W-1:0]  k_q;
	logic              rd_pend_q;
	rec_t              cur_q;

	logic              out_vld_q;
	rec_t              out_rec_q;
	logic              out_fin_q;
	logic              out_ovf_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	rec_t              wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;
	rec_t              rdata;

	logic              in_acc;
	logic              out_free;
	logic              room;
	logic              swap;
	logic [CNT_W-1:0]  cnt_new;
	logic [CNT_W-1:0]  i_ext;

	assign in_acc   = rec_in.valid && rec_in.ready;
	assign out_free = !out_vld_q || res_out.ready;
	assign room     = cnt_q < CNT_W'(MAX_RECORDS);
	assign swap     = cur_q.key > rdata.key;
	assign cnt_new  = room ? cnt_q + CNT_W'(1) : cnt_q;
	assign i_ext    = CNT_W'(i_q);

	assign rec_in.ready       = (state_q == ST_LOAD);
	assign res_out.valid      = out_vld_q;
	assign res_out.out_key    = out_rec_q.key;
	assign res_out.out_tag    = out_rec_q.tag;
	assign res_out.final_out  = out_fin_q;
	assign res_out.overflowed = out_ovf_q;

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = cur_q;
		re    = 1'b0;
		raddr = '0;
		unique case (state_q)
			ST_LOAD: begin
				we          = in_acc && room;
				waddr       = cnt_q[ADDR_W-1:0];
				wdata.key   = rec_in.sort_key;
				wdata.tag   = rec_in.record_tag;
			end
			ST_RDI: begin
				re    = 1'b1;
				raddr = i_q;
			end
			ST_HEAD: begin
				re    = 1'b1;
				raddr = ADDR_W'(i_ext + CNT_W'(1));
			end
			ST_SCAN: begin
				we    = swap;
				waddr = j_s1;
				re    = j_q < cnt_q;
				raddr = j_q[ADDR_W-1:0];
			end
			ST_WBI: begin
				we    = 1'b1;
				waddr = i_q;
			end
			ST_EMIT: begin
				re    = !rd_pend_q && (k_q < cnt_q);
				raddr = k_q[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	res_ram #(
		.DEPTH(MAX_RECORDS),
		.WIDTH(REC_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			j_s1      <= '0;
			k_q       <= '0;
			rd_pend_q <= 1'b0;
			cur_q     <= '0;
			out_vld_q <= 1'b0;
			out_rec_q <= '0;
			out_fin_q <= 1'b0;
			out_ovf_q <= 1'b0;
		end else begin
			if (out_vld_q && res_out.ready && !(state_q == ST_EMIT && rd_pend_q)) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_new;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (rec_in.last_record) begin
							i_q <= '0;
							k_q <= '0;
							if (cnt_new >= CNT_W'(2)) begin
								state_q <= ST_RDI;
							end else begin
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_RDI: begin
					state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					cur_q   <= rdata;
					j_s1    <= ADDR_W'(i_ext + CNT_W'(1));
					j_q     <= i_ext + CNT_W'(2);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (swap) begin
						cur_q <= rdata;
					end
					if (j_q < cnt_q) begin
						j_s1 <= j_q[ADDR_W-1:0];
						j_q  <= j_q + CNT_W'(1);
					end else begin
						state_q <= ST_WBI;
					end
				end
				ST_WBI: begin
					if (i_ext + CNT_W'(2) < cnt_q) begin
						i_q     <= i_q + ADDR_W'(1);
						state_q <= ST_RDI;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!rd_pend_q && (k_q < cnt_q)) begin
						rd_pend_q <= 1'b1;
						k_q       <= k_q + CNT_W'(1);
					end
					if (rd_pend_q && out_free) begin
						rd_pend_q <= 1'b0;
						out_vld_q <= 1'b1;
						out_rec_q <= rdata;
						out_fin_q <= (k_q == cnt_q);
						out_ovf_q <= ovf_q;
						if (k_q == cnt_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_sort_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDI || state_q == ST_HEAD || state_q == ST_SCAN || state_q == ST_WBI)
		|-> (cnt_q >= CNT_W'(2)))
		else $error("sort running on fewer than two records");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((j_q <= cnt_q) && (CNT_W'(j_s1) < cnt_q) && (i_q < j_s1)))
		else $error("scan index outside the loaded set");

	a_ovf_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == CNT_W'(MAX_RECORDS)))
		else $error("overflow flagged with room left");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (k_q <= cnt_q))
		else $error("emit index past the loaded set");
`endif
endmodule

// ----- rtl/res_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module res_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
